>>> src/gou_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gou_pkg: shared types and arithmetic for the optimizer update unit
// Config layout, queue item, Q8.24 rounding and saturation helpers.
// ----------------------------------------------------------------------------
package gou_pkg;

  localparam int unsigned GOU_ENTRIES   = 4096;
  localparam int unsigned GOU_BATCH_MAX = 256;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned ENTRY_W  = 12;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FACTOR_W = 25;
  localparam int unsigned BATCH_W  = 9;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [FACTOR_W-1:0] ONE_Q24 = 25'd16777216;

  typedef enum logic [1:0] {
    MODE_MOMENTUM = 2'd0,
    MODE_RMSPROP  = 2'd1,
    MODE_ADAGRAD  = 2'd2,
    MODE_ADAM     = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_LEARN_RATE  = 3'd1,
    CFG_MOMENTUM    = 3'd2,
    CFG_DECAY_GAMMA = 3'd3,
    CFG_BETA_FIRST  = 3'd4,
    CFG_BETA_SECOND = 3'd5,
    CFG_BATCH_SIZE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    mode_e                mode;
    logic [FACTOR_W-1:0]  learning_rate;
    logic [FACTOR_W-1:0]  momentum_coeff;
    logic [FACTOR_W-1:0]  decay_gamma;
    logic [FACTOR_W-1:0]  beta_first;
    logic [FACTOR_W-1:0]  beta_second;
    logic [BATCH_W-1:0]   batch_size;
  } cfg_t;

  // bias set: value holds the error term, else the finished batch sum
  typedef struct packed {
    logic                     bias;
    logic [ENTRY_W-1:0]       entry;
    logic signed [ACC_W-1:0]  value;
  } item_t;

  // add half an LSB, floor to Q8.24
  function automatic logic signed [67:0] rnd24(input logic signed [67:0] x);
    logic signed [67:0] t;
    t = x + 68'sd8388608;
    return t >>> 24;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    if (x > 68'sd2147483647) return 32'sh7fffffff;
    else if (x < -68'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [31:0] satpos32(input logic signed [67:0] x);
    if (x < 68'sd0) return 32'sd0;
    else if (x > 68'sd2147483647) return 32'sh7fffffff;
    else return x[31:0];
  endfunction

  // sign and magnitude back to saturated two's complement
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [55:0] mag);
    if (!neg) return (mag > 56'h7fffffff) ? 32'sh7fffffff : mag[31:0];
    else return (mag > 56'h80000000) ? 32'sh80000000 : 32'(32'd0 - mag[31:0]);
  endfunction

  function automatic logic [FACTOR_W-1:0] fclip(input logic [FACTOR_W-1:0] f);
    return (f > ONE_Q24) ? ONE_Q24 : f;
  endfunction

endpackage

>>> src/gradient_optimizer_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_optimizer_update_unit: per-parameter optimizer step
// Front accumulates samples, back updates moment stores and emits deltas.
// ----------------------------------------------------------------------------
// Users: weight samples (op 0) are taken one at a time and only add their
// rounded activation x error product to the batch sum; the sample flagged
// last, and every bias item (op 1), queues a gradient for the back end and
// later yields one transfer on the output with the delta to subtract.
// The back end is a sequencer around one multiplier, a restoring divider
// (one quotient bit per step) and a bit-pair square root. The output
// register lets the back end move to the next item while a delta waits
// to be taken, and a two-entry queue decouples the input side from the
// back end.
// After reset the moment stores are cleared, one entry per cycle, over all
// ENTRIES entries (4096 by default); inputs queue meanwhile, no results
// appear. Config writes are always ready; write only when the block is idle.
// Entry numbers wrap modulo ENTRIES for the stores.
// ----------------------------------------------------------------------------
module gradient_optimizer_update_unit import gou_pkg::*; #(
  parameter int unsigned ENTRIES   = GOU_ENTRIES,
  parameter int unsigned BATCH_MAX = GOU_BATCH_MAX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [ENTRY_W-1:0]        entry_i,
  input  logic signed [DATA_W-1:0]  activation_i,
  input  logic signed [DATA_W-1:0]  error_term_i,
  input  logic                      last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ENTRY_W-1:0]        out_entry_o,
  output logic signed [DATA_W-1:0]  delta_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [FACTOR_W-1:0]       cfg_data_i
);

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= MODE_MOMENTUM;
      cfg_q.learning_rate  <= 25'd167772;
      cfg_q.momentum_coeff <= 25'd15099494;
      cfg_q.decay_gamma    <= 25'd15099494;
      cfg_q.beta_first     <= 25'd15099494;
      cfg_q.beta_second    <= 25'd16760439;
      cfg_q.batch_size     <= 9'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:        cfg_q.mode           <= mode_e'(cfg_data_i[1:0]);
        CFG_LEARN_RATE:  cfg_q.learning_rate  <= cfg_data_i;
        CFG_MOMENTUM:    cfg_q.momentum_coeff <= cfg_data_i;
        CFG_DECAY_GAMMA: cfg_q.decay_gamma    <= cfg_data_i;
        CFG_BETA_FIRST:  cfg_q.beta_first     <= cfg_data_i;
        CFG_BETA_SECOND: cfg_q.beta_second    <= cfg_data_i;
        CFG_BATCH_SIZE:  cfg_q.batch_size     <= cfg_data_i[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  gou_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .entry_i,
    .activation_i,
    .error_term_i,
    .last_sample_i,
    .push_o (push),
    .item_o (front_item),
    .full_i (full)
  );

  gou_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  gou_back #(
    .ENTRIES   (ENTRIES),
    .BATCH_MAX (BATCH_MAX)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_entry_o,
    .delta_o
  );

endmodule

>>> src/gou_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gou_front: input stage
// Takes items, accumulates weight products, queues finished gradients.
// ----------------------------------------------------------------------------
module gou_front import gou_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [ENTRY_W-1:0]        entry_i,
  input  logic signed [DATA_W-1:0]  activation_i,
  input  logic signed [DATA_W-1:0]  error_term_i,
  input  logic                      last_sample_i,
  output logic                      push_o,
  output item_t                     item_o,
  input  logic                      full_i
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_PUSH} fstate_e;

  fstate_e                  state_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [67:0]       acc_sum;
  logic signed [DATA_W-1:0] act_q, err_q;
  logic signed [63:0]       prod_q;
  logic                     last_q;
  item_t                    item_q;

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign item_o     = item_q;

  always_comb begin
    acc_sum = 68'(acc_q) + rnd24(68'(prod_q));
    if (acc_sum > 68'sd140737488355327) acc_new = 48'sh7fffffffffff;
    else if (acc_sum < -68'sd140737488355328) acc_new = 48'sh800000000000;
    else acc_new = acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= act_q * err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      acc_q   <= '0;
      act_q   <= '0;
      err_q   <= '0;
      last_q  <= 1'b0;
      item_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            act_q        <= activation_i;
            err_q        <= error_term_i;
            last_q       <= last_sample_i;
            item_q.bias  <= op_i;
            item_q.entry <= entry_i;
            item_q.value <= 48'(error_term_i);
            state_q      <= op_i ? F_PUSH : F_MUL;
          end
        end
        F_MUL: state_q <= F_ACC;
        F_ACC: begin
          if (last_q) begin
            item_q.value <= acc_new;
            acc_q        <= '0;
            state_q      <= F_PUSH;
          end else begin
            acc_q   <= acc_new;
            state_q <= F_IDLE;
          end
        end
        F_PUSH: if (!full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

>>> src/gou_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gou_queue: short queue between front and back
// Small first-in first-out store of gradient items.
// ----------------------------------------------------------------------------
module gou_queue import gou_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = store_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

endmodule

>>> src/gou_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gou_back: update sequencer
// Moment stores, shared multiplier, shared divider and square root.
// ----------------------------------------------------------------------------
module gou_back import gou_pkg::*; #(
  parameter int unsigned ENTRIES   = GOU_ENTRIES,
  parameter int unsigned BATCH_MAX = GOU_BATCH_MAX
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      empty_i,
  input  item_t                     item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ENTRY_W-1:0]        out_entry_o,
  output logic signed [DATA_W-1:0]  delta_o
);

  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned DIV_STEPS = 56;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_GSQ, ST_GSQR, ST_MA, ST_MB, ST_SUM,
    ST_ADA, ST_ROOT, ST_NUM, ST_DLD, ST_OUT
  } bstate_e;

  bstate_e                  state_q;
  logic                     phase_q;
  logic [IDX_W-1:0]         clr_q, idx_q, idx_d;
  logic [ENTRY_W-1:0]       entry_q;
  logic signed [31:0]       g_q, gsq_q, m_new_q, s_new_q, res_q;
  logic signed [31:0]       s_rd_q, m_rd_q;
  logic signed [65:0]       acc_q, prod_q, prod_d;
  logic signed [32:0]       mul_a, mul_b;
  logic [55:0]              sq_x_q, sq_r_q, sq_bit_q, sq_t;
  logic [27:0]              dv_rem_q, dv_div_q, rem_d;
  logic [55:0]              dv_quo_q, quo_d;
  logic [28:0]              dv_shift, dv_trial;
  logic                     dv_neg_q, dv_batch_q, dv_ge;
  logic [5:0]               dv_cnt_q;
  logic signed [31:0]       dv_res;
  logic signed [31:0]       sum_s, sum_p, ada_s;
  logic signed [67:0]       sum_r;
  logic [47:0]              abs48;
  logic [65:0]              abs66;
  logic [12:0]              bs;
  logic                     out_fire;
  logic [FACTOR_W-1:0]      f_lr, f_mom, f_gam, f_b1, f_b2;
  logic [FACTOR_W-1:0]      f_a, f_b;
  logic                     wr_en, wr_first;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [31:0]       wr_s, wr_m;
  logic                     out_valid_q;
  logic [ENTRY_W-1:0]       out_entry_q;
  logic signed [DATA_W-1:0] out_delta_q;

  logic signed [31:0] first_mem  [ENTRIES];
  logic signed [31:0] second_mem [ENTRIES];

  // entry modulo store depth by conditional subtraction
  always_comb begin
    logic [25:0] v, lim;
    v = 26'(item_i.entry);
    for (int k = 8; k >= 0; k--) begin
      lim = 26'(ENTRIES) << k;
      if (v >= lim) v = v - lim;
    end
    idx_d = v[IDX_W-1:0];
  end

  always_comb begin
    bs = 13'(cfg_i.batch_size);
    if (bs == 13'd0) bs = 13'd1;
    if (bs > 13'(BATCH_MAX)) bs = 13'(BATCH_MAX);
  end

  assign f_lr  = fclip(cfg_i.learning_rate);
  assign f_mom = fclip(cfg_i.momentum_coeff);
  assign f_gam = fclip(cfg_i.decay_gamma);
  assign f_b1  = fclip(cfg_i.beta_first);
  assign f_b2  = fclip(cfg_i.beta_second);
  assign abs48 = item_i.value[ACC_W-1] ? 48'(-item_i.value) : item_i.value;
  assign abs66 = prod_q[65] ? 66'(-prod_q) : prod_q;

  // decay factor for the moment being updated
  always_comb begin
    unique case (cfg_i.mode)
      MODE_MOMENTUM: f_a = f_mom;
      MODE_RMSPROP:  f_a = f_gam;
      MODE_ADAGRAD:  f_a = f_gam;
      default:       f_a = phase_q ? f_b2 : f_b1;
    endcase
    f_b = ONE_Q24 - f_a;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GSQ: begin
        mul_a = 33'(g_q);
        mul_b = 33'(g_q);
      end
      ST_MA: begin
        mul_a = $signed({8'd0, f_a});
        mul_b = (cfg_i.mode == MODE_ADAM && !phase_q) ? 33'(m_rd_q) : 33'(s_rd_q);
      end
      ST_MB: begin
        if (cfg_i.mode == MODE_MOMENTUM) begin
          mul_a = $signed({8'd0, f_lr});
          mul_b = 33'(g_q);
        end else begin
          mul_a = $signed({8'd0, f_b});
          mul_b = (cfg_i.mode == MODE_ADAM && !phase_q) ? 33'(g_q) : 33'(gsq_q);
        end
      end
      ST_NUM: begin
        mul_a = $signed({8'd0, f_lr});
        mul_b = (cfg_i.mode == MODE_ADAM) ? 33'(m_new_q) : 33'(g_q);
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    sum_r = rnd24(68'(acc_q) + 68'(prod_q));
    sum_s = sat32(sum_r);
    sum_p = satpos32(sum_r);
    ada_s = satpos32(68'(s_rd_q) + 68'(gsq_q));
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    dv_shift = {dv_rem_q, dv_quo_q[55]};
    dv_trial = dv_shift - {1'b0, dv_div_q};
    dv_ge    = !dv_trial[28];
    rem_d    = dv_ge ? dv_trial[27:0] : dv_shift[27:0];
    quo_d    = {dv_quo_q[54:0], dv_ge};
    dv_res   = sat_mag(dv_neg_q, quo_d);
  end

  assign sq_t     = sq_r_q + sq_bit_q;
  assign out_fire = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_entry_q;
  assign delta_o     = out_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= 1'b0;
      clr_q       <= '0;
      idx_q       <= '0;
      entry_q     <= '0;
      g_q         <= '0;
      gsq_q       <= '0;
      m_new_q     <= '0;
      s_new_q     <= '0;
      res_q       <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      sq_x_q      <= '0;
      sq_r_q      <= '0;
      sq_bit_q    <= '0;
      dv_rem_q    <= '0;
      dv_div_q    <= '0;
      dv_quo_q    <= '0;
      dv_neg_q    <= 1'b0;
      dv_batch_q  <= 1'b0;
      dv_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_entry_q <= '0;
      out_delta_q <= '0;
    end else begin
      prod_q <= prod_d;
      if (out_valid_q && !out_stall_i && !out_fire) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(ENTRIES - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!empty_i) begin
            entry_q <= item_i.entry;
            idx_q   <= idx_d;
            if (item_i.bias) begin
              g_q     <= item_i.value[31:0];
              state_q <= ST_GSQ;
            end else begin
              dv_quo_q   <= 56'(abs48);
              dv_rem_q   <= '0;
              dv_div_q   <= 28'(bs);
              dv_neg_q   <= item_i.value[ACC_W-1];
              dv_cnt_q   <= '0;
              dv_batch_q <= 1'b1;
              state_q    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          dv_rem_q <= rem_d;
          dv_quo_q <= quo_d;
          dv_cnt_q <= dv_cnt_q + 1'b1;
          if (dv_cnt_q == 6'(DIV_STEPS - 1)) begin
            if (dv_batch_q) begin
              g_q     <= dv_res;
              state_q <= ST_GSQ;
            end else begin
              res_q   <= dv_res;
              state_q <= ST_OUT;
            end
          end
        end
        ST_GSQ: state_q <= ST_GSQR;
        ST_GSQR: begin
          gsq_q   <= satpos32(rnd24(68'(prod_q)));
          phase_q <= 1'b0;
          state_q <= (cfg_i.mode == MODE_ADAGRAD) ? ST_ADA : ST_MA;
        end
        ST_MA: state_q <= ST_MB;
        ST_MB: begin
          acc_q   <= prod_q;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (cfg_i.mode == MODE_MOMENTUM) begin
            s_new_q <= sum_s;
            res_q   <= sum_s;
            state_q <= ST_OUT;
          end else if (cfg_i.mode == MODE_ADAM && !phase_q) begin
            m_new_q <= sum_s;
            phase_q <= 1'b1;
            state_q <= ST_MA;
          end else begin
            s_new_q  <= sum_p;
            sq_x_q   <= (56'(sum_p) + 56'd1) << 24;
            sq_r_q   <= '0;
            sq_bit_q <= 56'd1 << 54;
            state_q  <= ST_ROOT;
          end
        end
        ST_ADA: begin
          s_new_q  <= ada_s;
          sq_x_q   <= (56'(ada_s) + 56'd1) << 24;
          sq_r_q   <= '0;
          sq_bit_q <= 56'd1 << 54;
          state_q  <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_x_q >= sq_t) begin
            sq_x_q <= sq_x_q - sq_t;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q == 56'd1) state_q <= ST_NUM;
        end
        ST_NUM: state_q <= ST_DLD;
        ST_DLD: begin
          dv_quo_q   <= abs66[55:0];
          dv_rem_q   <= '0;
          dv_div_q   <= sq_r_q[27:0];
          dv_neg_q   <= prod_q[65];
          dv_cnt_q   <= '0;
          dv_batch_q <= 1'b0;
          state_q    <= ST_DIV;
        end
        ST_OUT: begin
          if (out_fire) begin
            out_valid_q <= 1'b1;
            out_entry_q <= entry_q;
            out_delta_q <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en    = 1'b1;
      wr_first = 1'b1;
      wr_addr  = clr_q;
      wr_s     = '0;
      wr_m     = '0;
    end else begin
      wr_en    = out_fire;
      wr_first = out_fire && (cfg_i.mode == MODE_ADAM);
      wr_addr  = idx_q;
      wr_s     = s_new_q;
      wr_m     = m_new_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) second_mem[wr_addr] <= wr_s;
    if (wr_first) first_mem[wr_addr] <= wr_m;
    s_rd_q <= second_mem[idx_q];
    m_rd_q <= first_mem[idx_q];
  end

endmodule

>>> src/gou_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gou_checker: port-level checks
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
module gou_checker import gou_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [ENTRY_W-1:0]        out_entry_o,
  input logic signed [DATA_W-1:0]  delta_o
);

  // front takes one item at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_entry_o) && $stable(delta_o))
    else $error("stalled result changed");

  // no result is valid straight out of reset
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result straight after reset");

endmodule

bind gradient_optimizer_update_unit gou_checker u_gou_checker (.*);
